@@ hw/rtl/hcm_pkg.sv @@
package hcm_pkg;

	// Block geometry.
	localparam int BLOCK_SYMBOLS = 8;
	localparam int SYM_W         = 5;
	localparam int BLOCK_W       = BLOCK_SYMBOLS * SYM_W;
	localparam int ROW_W         = $clog2(BLOCK_SYMBOLS);
	localparam int KEY_IDX_W     = 6;
	localparam int KEY_ENTRIES   = BLOCK_SYMBOLS * BLOCK_SYMBOLS;

	// Alphabet size, and the widths of the row dot product.
	localparam int MODULUS = 29;
	localparam int PROD_W  = 2 * SYM_W;
	localparam int SUM_W   = PROD_W + $clog2(BLOCK_SYMBOLS);

	// Reduction of the row sum by multiplying with a rounded-up reciprocal.
	localparam int RECIP_SHIFT = SUM_W + 5;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + MODULUS - 1) / MODULUS;
	localparam int RECIP_W     = $clog2(RECIP + 1);

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [BLOCK_SYMBOLS-1:0][SYM_W-1:0] block_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	typedef enum logic [1:0] {
		CMD_LOAD_KEY = 2'd0,
		CMD_ENCRYPT  = 2'd1,
		CMD_DECRYPT  = 2'd2,
		CMD_RESTART  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_OFB = 2'd2,
		MODE_CFB = 2'd3
	} mode_t;

	typedef enum logic {
		CFG_CHAIN_MODE  = 1'b0,
		CFG_INIT_VECTOR = 1'b1
	} cfg_idx_t;

	// Tag that travels with one key row through the row unit.
	typedef struct packed {
		logic valid;
		row_t row;
	} tag_t;

endpackage

@@ hw/rtl/hcm_in_if.sv @@
interface hcm_in_if import hcm_pkg::*; ();
	logic     valid;
	logic     ready;
	cmd_t     command;
	key_idx_t key_index;
	sym_t     key_value;
	block_t   block_in;

	modport source (output valid, output command, output key_index, output key_value,
		output block_in, input ready);
	modport sink (input valid, input command, input key_index, input key_value,
		input block_in, output ready);
endinterface

@@ hw/rtl/hcm_out_if.sv @@
interface hcm_out_if import hcm_pkg::*; ();
	logic   valid;
	logic   ready;
	block_t block_out;
	logic   bad_symbol;

	modport source (output valid, output block_out, output bad_symbol, input ready);
	modport sink (input valid, input block_out, input bad_symbol, output ready);
endinterface

@@ hw/rtl/hcm_cfg_if.sv @@
interface hcm_cfg_if import hcm_pkg::*; ();
	logic               valid;
	logic               ready;
	cfg_idx_t           index;
	logic [BLOCK_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hcm_row_unit.sv @@
// Shared row unit: one key row times the text vector, reduced modulo the alphabet size.
// Two register stages: the dot product, then the reduction.
module hcm_row_unit import hcm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  tag_t   tag_in,
	input  block_t key_row,
	input  block_t x_vec,
	output tag_t   tag_out,
	output sym_t   residue
);

	localparam int MUL_W = SUM_W + RECIP_W;

	tag_t             tag_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [SUM_W-1:0] dot;
	logic [MUL_W-1:0] scaled;
	logic [SUM_W-1:0] quo;
	logic [SUM_W-1:0] rem;

	always_comb begin
		dot = '0;
		for (int i = 0; i < BLOCK_SYMBOLS; i++) begin
			dot = dot + SUM_W'(PROD_W'(key_row[i]) * PROD_W'(x_vec[i]));
		end
	end

	// The quotient estimate is exact for every sum the row can produce, so one
	// subtraction of quotient times 29 (32 - 2 - 1) leaves the residue.
	assign scaled = MUL_W'(sum_s1) * MUL_W'(RECIP);
	assign quo    = SUM_W'(scaled >> RECIP_SHIFT);
	assign rem    = sum_s1 - ((quo << 5) - (quo << 1) - quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			sum_s1  <= '0;
			tag_out <= '0;
			residue <= '0;
		end else begin
			tag_s1  <= tag_in;
			sum_s1  <= dot;
			tag_out <= tag_s1;
			residue <= SYM_W'(rem);
		end
	end

endmodule

@@ hw/rtl/hill_cipher_chained_modes.sv @@
// Hill block cipher over a 29-symbol alphabet with ECB, CBC, OFB and CFB chaining.
// in_ch carries commands: load one key matrix entry, encrypt a block, decrypt a
// block, or restart the chain from the initial vector. A transaction on in_ch is
// taken whenever the block is idle. Load key and restart finish in the cycle of
// their transaction and give no result. Encrypt and decrypt give one result
// transaction on out_ch: the 40-bit block and the bad_symbol flag.
// cfg carries register writes (chain mode, initial vector); it is always ready
// and must only be used while the block is idle.
//
// An encrypt or decrypt transaction reads one key row per cycle from the key
// memory into the shared row unit; the rows pass through the memory read
// register and the two stages of the row unit, and the chaining add or subtract
// follows before the result is presented. The block is idle again from the cycle
// in which the result is presented.
//
// Reset clears the chain register, mode and initial vector; the key memory is
// not cleared and must be loaded before use. If the receiver stalls out_ch, the
// result register holds; the following block may still be accepted and worked
// on, and it waits in its final cycle until the held result has been taken.
module hill_cipher_chained_modes import hcm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hcm_in_if.sink    in_ch,
	hcm_out_if.source out_ch,
	hcm_cfg_if.sink   cfg
);

	localparam row_t LAST_ROW = row_t'(BLOCK_SYMBOLS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FINISH
	} state_t;

	state_t state_q;
	mode_t  mode_q;
	block_t iv_q;
	block_t chain_q;
	block_t p_q;
	block_t x_q;
	block_t y_q;
	logic   enc_q;
	logic   bad_q;
	row_t   rd_row_q;
	tag_t   rd_tag_s1;
	block_t key_row_s1;
	logic   out_valid_q;
	block_t out_block_q;
	logic   out_bad_q;

	tag_t   unit_tag;
	sym_t   unit_res;

	// Key matrix: one row of symbols per word, written one symbol at a time.
	block_t key_mem [BLOCK_SYMBOLS];

	logic   in_take;
	logic   is_block_cmd;
	logic   issue;
	logic   out_free;
	block_t p_in;
	block_t x_in;
	block_t post_out;
	block_t post_chain;
	row_t   key_row_idx;
	row_t   key_col_idx;
	logic   key_in_range;

	function automatic sym_t sym_reduce(input sym_t s);
		return (s >= SYM_W'(MODULUS)) ? s - SYM_W'(MODULUS) : s;
	endfunction

	function automatic block_t vec_reduce(input block_t a);
		block_t r;
		for (int i = 0; i < BLOCK_SYMBOLS; i++) begin
			r[i] = sym_reduce(a[i]);
		end
		return r;
	endfunction

	function automatic block_t vec_add(input block_t a, input block_t b);
		block_t         r;
		logic [SYM_W:0] s;
		for (int i = 0; i < BLOCK_SYMBOLS; i++) begin
			s = {1'b0, a[i]} + {1'b0, b[i]};
			if (s >= (SYM_W + 1)'(MODULUS)) begin
				s = s - (SYM_W + 1)'(MODULUS);
			end
			r[i] = s[SYM_W-1:0];
		end
		return r;
	endfunction

	function automatic block_t vec_sub(input block_t a, input block_t b);
		block_t         r;
		logic [SYM_W:0] s;
		for (int i = 0; i < BLOCK_SYMBOLS; i++) begin
			if (a[i] >= b[i]) begin
				s = {1'b0, a[i]} - {1'b0, b[i]};
			end else begin
				s = {1'b0, a[i]} + (SYM_W + 1)'(MODULUS) - {1'b0, b[i]};
			end
			r[i] = s[SYM_W-1:0];
		end
		return r;
	endfunction

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;
	assign is_block_cmd = (in_ch.command == CMD_ENCRYPT) || (in_ch.command == CMD_DECRYPT);
	assign issue       = (state_q == S_ISSUE);
	assign out_free    = !out_valid_q || out_ch.ready;

	assign cfg.ready = 1'b1;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.block_out  = out_block_q;
	assign out_ch.bad_symbol = out_bad_q;

	// Symbols 29 to 31 fold back to 0 to 2 before use.
	assign p_in = vec_reduce(in_ch.block_in);

	// Vector fed into the key matrix for this block.
	always_comb begin
		case (mode_q)
			MODE_ECB: x_in = p_in;
			MODE_CBC: x_in = (in_ch.command == CMD_ENCRYPT) ? vec_add(p_in, chain_q) : p_in;
			MODE_OFB: x_in = chain_q;
			MODE_CFB: x_in = chain_q;
			default:  x_in = p_in;
		endcase
	end

	// Chaining step once the matrix product y_q is complete.
	always_comb begin
		post_chain = chain_q;
		case (mode_q)
			MODE_ECB: begin
				post_out = y_q;
			end
			MODE_CBC: begin
				post_out   = enc_q ? y_q : vec_sub(y_q, chain_q);
				post_chain = enc_q ? y_q : p_q;
			end
			MODE_OFB: begin
				post_out   = enc_q ? vec_add(y_q, p_q) : vec_sub(p_q, y_q);
				post_chain = y_q;
			end
			MODE_CFB: begin
				post_out   = enc_q ? vec_add(y_q, p_q) : vec_sub(p_q, y_q);
				post_chain = enc_q ? post_out : p_q;
			end
			default: begin
				post_out = y_q;
			end
		endcase
	end

	assign key_row_idx  = row_t'(in_ch.key_index / KEY_IDX_W'(BLOCK_SYMBOLS));
	assign key_col_idx  = row_t'(in_ch.key_index % KEY_IDX_W'(BLOCK_SYMBOLS));
	assign key_in_range = int'(in_ch.key_index) < KEY_ENTRIES;

	// Key memory: symbol write on a load key transaction, registered row read
	// while rows are being issued. The two never happen in the same cycle.
	always_ff @(posedge clk) begin
		if (in_take && (in_ch.command == CMD_LOAD_KEY) && key_in_range) begin
			key_mem[key_row_idx][key_col_idx] <= sym_reduce(in_ch.key_value);
		end
		if (issue) begin
			key_row_s1 <= key_mem[rd_row_q];
		end
	end

	hcm_row_unit u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (rd_tag_s1),
		.key_row (key_row_s1),
		.x_vec   (x_q),
		.tag_out (unit_tag),
		.residue (unit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_ECB;
			iv_q        <= '0;
			chain_q     <= '0;
			p_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			enc_q       <= 1'b0;
			bad_q       <= 1'b0;
			rd_row_q    <= '0;
			rd_tag_s1   <= '0;
			out_valid_q <= 1'b0;
			out_block_q <= '0;
			out_bad_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_CHAIN_MODE:  mode_q <= mode_t'(cfg.data[1:0]);
					CFG_INIT_VECTOR: iv_q <= block_t'(cfg.data);
					default:         ;
				endcase
			end

			// In the final step a taken result is replaced there by the new one.
			if (out_ch.valid && out_ch.ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			rd_tag_s1.valid <= issue;
			rd_tag_s1.row   <= rd_row_q;

			if (unit_tag.valid) begin
				y_q[unit_tag.row] <= unit_res;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (in_ch.command == CMD_RESTART) begin
							chain_q <= vec_reduce(iv_q);
						end
						if (is_block_cmd) begin
							p_q      <= p_in;
							x_q      <= x_in;
							enc_q    <= (in_ch.command == CMD_ENCRYPT);
							bad_q    <= (p_in != in_ch.block_in);
							rd_row_q <= '0;
							state_q  <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					rd_row_q <= rd_row_q + row_t'(1);
					if (rd_row_q == LAST_ROW) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (unit_tag.valid && (unit_tag.row == LAST_ROW)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_block_q <= post_out;
						out_bad_q   <= bad_q;
						chain_q     <= post_chain;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Row results only come back while a block is in flight.
	a_row_result_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		unit_tag.valid |-> (state_q == S_ISSUE || state_q == S_WAIT))
		else $error("row result outside a block");

	// An accepted block starts issuing from the first key row.
	a_block_starts_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && is_block_cmd) |=> (state_q == S_ISSUE && rd_row_q == '0))
		else $error("block did not start at row zero");

	// Leaving the final step always presents a result.
	a_finish_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished block gave no result");

endmodule
